/* hdl/srcls_pkg.sv */
// Package for the sequence reader with call/loop stack.
// Holds request codes and the fixed field widths; used by
// sequence_reader_call_loop_stack_unit.
package srcls_pkg;

  // Fixed field widths
  localparam int REQ_W     = 3;
  localparam int OPND_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int VALUE_W   = 28;
  localparam int ADDR_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int IN_DATA_W = 40;   // operand + data_byte
  localparam int OUT_USER_W = 2;   // ok, value_done

  // Request codes
  localparam logic [REQ_W-1:0] REQ_RESTART    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CALL       = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOOP_START = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOOP_END   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RETURN     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_BYTE       = 3'd5;
  localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd6;

  // Variable-length decoder
  localparam logic [1:0] VLQ_LAST_BYTE = 2'd3;  // bytes taken before a fourth byte

endpackage

/* hdl/sequence_reader_call_loop_stack_unit.sv */
// Sequence reader: cursor, call/loop stack and MIDI variable-length decoder.
// Top level; depends on srcls_pkg.
//
//  channel  | direction | tdata fields (low bit up)                       | tuser
//  ---------+-----------+--------------------------------------------------+---------------
//  in_      | slave     | operand[31:0], data_byte[39:32]                  | req_type
//  out_     | master    | value, cursor_address, stack_entry_address, depth| ok, value_done
//  cfg_     | write     | sequence_base (cfg_wr_data, 32 bits)             | -
//
// One item per cycle: the stack, cursor and decoder update in the cycle an item
// transfers, and the result lands on the same edge in the output register, or in
// the skid register, which holds one more result, so an item still transfers while
// a result waits; in_tready drops only while the skid register is full.
// Synchronous active-low reset clears cursor, depth, decoder, base, stack and valids.
// Restart clears the stack as well; a call keeps the loop count left in its slot,
// so a loop end on a call entry sees whatever count that slot last held.
module sequence_reader_call_loop_stack_unit #(
  parameter int STACK_DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [srcls_pkg::ADDR_W-1:0]    cfg_wr_data,     // sequence_base
  // request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [srcls_pkg::IN_DATA_W-1:0] in_tdata,        // operand, data_byte
  input  logic [srcls_pkg::REQ_W-1:0]     in_tuser,        // req_type
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // value, cursor_address, stack_entry_address, depth, zero fill
  output logic [((2*srcls_pkg::ADDR_W + srcls_pkg::VALUE_W
                  + $clog2(STACK_DEPTH+1) + 7) / 8) * 8 - 1:0] out_tdata,
  output logic [srcls_pkg::OUT_USER_W-1:0] out_tuser       // ok, value_done
);

  import srcls_pkg::*;

  localparam int DW      = $clog2(STACK_DEPTH + 1);   // depth counter width
  localparam int IW      = $clog2(STACK_DEPTH);       // stack position width
  localparam int FIELD_W = 2*ADDR_W + VALUE_W + DW;
  localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;
  localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

  typedef struct packed {
    logic [DW-1:0]      depth;
    logic [ADDR_W-1:0]  entry_addr;
    logic [ADDR_W-1:0]  cursor_addr;
    logic [VALUE_W-1:0] value;
    logic               value_done;
    logic               ok;
  } result_t;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  base_r;
  logic [ADDR_W-1:0]  cursor_r, cursor_nxt;
  logic [DW-1:0]      depth_r, depth_nxt;
  logic [VALUE_W-1:0] partial_r, partial_nxt;
  logic [1:0]         taken_r, taken_nxt;

  // Stack slots by position: slot 0 is the bottom, slot depth-1 the top.
  logic [ADDR_W-1:0]  stk_cur_r [STACK_DEPTH];
  logic [COUNT_W-1:0] stk_cnt_r [STACK_DEPTH];

  result_t            res_nxt, out_r, skid_r;
  logic               out_vld_r, skid_vld_r;

  // Request fields
  logic [OPND_W-1:0]  opnd;
  logic [BYTE_W-1:0]  dbyte;
  logic               in_fire, out_fire;

  // Stack controls
  logic               push, push_loop, cnt_upd, stk_clr;
  logic [COUNT_W-1:0] cnt_dec;
  logic [VALUE_W-1:0] shifted;
  logic [DW-1:0]      top_w;
  logic [IW-1:0]      top_idx, push_idx, qidx;
  logic               qhit;

  assign opnd  = in_tdata[OPND_W-1:0];
  assign dbyte = in_tdata[OPND_W +: BYTE_W];

  assign in_tready = !skid_vld_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_vld_r && out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tuser  = {out_r.value_done, out_r.ok};
  assign out_tdata  = TDATA_W'({out_r.depth, out_r.entry_addr, out_r.cursor_addr,
                                out_r.value});

  // ---------------------------------------------------------------------------
  // Next state and result for the item at the input
  // ---------------------------------------------------------------------------
  always_comb begin
    cursor_nxt  = cursor_r;
    depth_nxt   = depth_r;
    partial_nxt = partial_r;
    taken_nxt   = taken_r;
    push        = 1'b0;
    push_loop   = 1'b0;
    cnt_upd     = 1'b0;
    stk_clr     = 1'b0;

    res_nxt            = '0;
    res_nxt.ok         = 1'b1;

    top_w    = depth_r - DW'(1);
    top_idx  = top_w[IW-1:0];
    push_idx = depth_r[IW-1:0];
    qidx     = opnd[IW-1:0];

    cnt_dec = (stk_cnt_r[top_idx] == '0) ? '0 : stk_cnt_r[top_idx] - COUNT_W'(1);
    shifted = {partial_r[VALUE_W-8:0], dbyte[6:0]};

    // Query index counts from the bottom of the stack
    qhit = (opnd < OPND_W'(depth_r));

    case (in_tuser)
      REQ_RESTART: begin
        cursor_nxt  = '0;
        depth_nxt   = '0;
        partial_nxt = '0;
        taken_nxt   = '0;
        stk_clr     = 1'b1;
      end
      REQ_CALL, REQ_LOOP_START: begin
        if (depth_r == DEPTH_FULL) begin
          res_nxt.ok = 1'b0;
        end else begin
          push      = 1'b1;
          depth_nxt = depth_r + DW'(1);
          if (in_tuser == REQ_CALL) begin
            cursor_nxt = opnd;
          end else begin
            push_loop = 1'b1;
          end
        end
      end
      REQ_LOOP_END: begin
        if (depth_r == '0) begin
          res_nxt.ok = 1'b0;
        end else if (cnt_dec == '0) begin
          // count exhausted: drop the entry, cursor stays
          depth_nxt = depth_r - DW'(1);
        end else begin
          cnt_upd    = 1'b1;
          cursor_nxt = stk_cur_r[top_idx];
        end
      end
      REQ_RETURN: begin
        if (depth_r == '0) begin
          res_nxt.ok = 1'b0;
        end else begin
          depth_nxt  = depth_r - DW'(1);
          cursor_nxt = stk_cur_r[top_idx];
        end
      end
      REQ_BYTE: begin
        cursor_nxt = cursor_r + ADDR_W'(1);
        if (taken_r == '0) begin
          if (!dbyte[7]) begin
            res_nxt.value_done = 1'b1;
            res_nxt.value      = VALUE_W'(dbyte);
          end else begin
            partial_nxt = VALUE_W'(dbyte[6:0]);
            taken_nxt   = 2'd1;
          end
        end else if (!dbyte[7]) begin
          res_nxt.value_done = 1'b1;
          res_nxt.value      = shifted;
          partial_nxt        = '0;
          taken_nxt          = '0;
        end else if (taken_r == VLQ_LAST_BYTE) begin
          // overlong encoding completes as zero
          res_nxt.value_done = 1'b1;
          partial_nxt        = '0;
          taken_nxt          = '0;
        end else begin
          partial_nxt = shifted;
          taken_nxt   = taken_r + 2'd1;
        end
      end
      REQ_QUERY: begin
        if (qhit) begin
          res_nxt.entry_addr = base_r + stk_cur_r[qidx];
        end else begin
          res_nxt.ok = 1'b0;
        end
      end
      default: begin
        res_nxt.ok = 1'b0;
      end
    endcase

    res_nxt.cursor_addr = base_r + cursor_nxt;
    res_nxt.depth       = depth_nxt;
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      cursor_r   <= '0;
      depth_r    <= '0;
      partial_r  <= '0;
      taken_r    <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (in_fire) begin
        cursor_r  <= cursor_nxt;
        depth_r   <= depth_nxt;
        partial_r <= partial_nxt;
        taken_r   <= taken_nxt;
      end
      // Output register plus one skid entry
      if (skid_vld_r) begin
        if (out_fire) begin
          skid_vld_r <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_vld_r || out_fire) begin
          out_vld_r <= 1'b1;
        end else begin
          skid_vld_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (!out_vld_r || out_fire) begin
        out_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stack slots: restart clears all, push writes the slot at depth, loop end rewrites the top count
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stk_cur_r[i] <= '0;
        stk_cnt_r[i] <= '0;
      end
    end else if (in_fire) begin
      if (stk_clr) begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
          stk_cur_r[i] <= '0;
          stk_cnt_r[i] <= '0;
        end
      end else begin
        if (push) begin
          stk_cur_r[push_idx] <= cursor_r;
        end
        if (push_loop) begin
          stk_cnt_r[push_idx] <= opnd[COUNT_W-1:0];
        end
        if (cnt_upd) begin
          stk_cnt_r[top_idx] <= cnt_dec;
        end
      end
    end
  end

endmodule
